// ===== hdl/assert_macros.svh =====
// Assertion shorthands for the go-back-n sender RTL.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge out of reset.
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/gbn_pkg.sv =====
// Shared types and constants for the go-back-n sender.
// No dependencies; used by go_back_n_sender_core and the testbench.
package gbn_pkg;

	localparam int unsigned MAX_WINDOW_DEF     = 32;
	localparam int unsigned TEARDOWN_COUNT_DEF = 10;

	localparam logic [15:0] DATA_SIZE_RST   = 16'd8192;
	localparam logic [8:0]  CHUNK_SIZE_RST  = 9'd256;
	localparam logic [5:0]  WINDOW_SIZE_RST = 6'd4;
	localparam logic [3:0]  MAX_TRIES_RST   = 4'd10;

	localparam logic [16:0] SEQ_NONE   = 17'h1FFFF;
	localparam logic [3:0]  RETRY_MAX  = 4'd15;
	localparam logic [7:0]  TYPE_ACK   = 8'd2;
	localparam int unsigned DIV_STEPS  = 16;
	localparam int unsigned MUL_STEPS  = 9;

	typedef enum logic [1:0] {
		OP_START   = 2'd0,
		OP_ACK     = 2'd1,
		OP_TIMEOUT = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		KIND_DATA     = 2'd0,
		KIND_TEARDOWN = 2'd1,
		KIND_GAVE_UP  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		CFG_DATA_SIZE   = 2'd0,
		CFG_CHUNK_SIZE  = 2'd1,
		CFG_WINDOW_SIZE = 2'd2,
		CFG_MAX_TRIES   = 2'd3
	} cfg_idx_t;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_DIV    = 6'b000010,
		S_MUL    = 6'b000100,
		S_BURST  = 6'b001000,
		S_TEAR   = 6'b010000,
		S_GIVEUP = 6'b100000
	} state_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  ack_type;
		logic [15:0] ack_seq;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] seq_no;
		logic [15:0] byte_offset;
		logic [8:0]  length;
		logic        last;
	} out_item_t;

endpackage

// ===== hdl/go_back_n_sender_core.sv =====
// Go-back-n ARQ sender core: packet descriptor sequencer with a shared add/sub unit.
// Depends on gbn_pkg and assert_macros.svh.
//
// Usage:
//   Input items (in_valid/in_stall, in_item) are commands: start a transfer,
//   an acknowledgement arrived, or the retransmit timer expired. Each command
//   yields zero or more result items on out_valid/out_stall (out_item): data
//   packet descriptors, teardown packets or a single gave-up marker; the final
//   result of a command carries last.
//   The block takes one command at a time and holds in_stall high until the
//   command's final result sits in the output register.
//   Flow: a start runs the restoring divider (packet count), then the shift-add
//   multiplier (offset of the window base), then one descriptor per unstalled
//   cycle; an empty transfer goes from the divider to teardown. A resend by ack
//   or timeout runs the multiplier, even with an empty window, then its
//   descriptors. Teardown and give-up emit one item per unstalled cycle; an
//   ignored command frees the input for the next cycle. One add/sub unit serves the
//   divider and multiplier; an output stall holds the result and pauses emission.
//   Configuration (cfg_valid/cfg_ready) is always ready; write it only idle.
//   Reset returns registers to their defaults and the core to no transfer.
module go_back_n_sender_core #(
	parameter int unsigned MAX_WINDOW     = gbn_pkg::MAX_WINDOW_DEF,
	parameter int unsigned TEARDOWN_COUNT = gbn_pkg::TEARDOWN_COUNT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  gbn_pkg::in_item_t in_item,
	output logic              out_valid,
	input  logic              out_stall,
	output gbn_pkg::out_item_t out_item,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data
);
	import gbn_pkg::*;

	`include "assert_macros.svh"

	// Step counter covers the divider, the multiplier and the teardown run.
	localparam int unsigned TW = (TEARDOWN_COUNT > 1) ? $clog2(TEARDOWN_COUNT) : 1;
	localparam int unsigned SW = (TW > 4) ? TW : 4;
	// Window count must hold MAX_WINDOW itself.
	localparam int unsigned WW = $clog2(MAX_WINDOW + 1) > 6 ? $clog2(MAX_WINDOW + 1) : 6;

	// Configuration registers
	logic [15:0] data_size_q;
	logic [8:0]  chunk_size_q;
	logic [5:0]  window_size_q;
	logic [3:0]  max_tries_q;

	// Protocol state
	logic [15:0] base_q;
	logic [16:0] hs_q;
	logic [16:0] ha_q;
	logic [3:0]  retry_q;
	logic [16:0] pt_q;
	logic        fin_q;

	// Sequencer and shared-unit working registers
	state_t      state_q;
	logic [SW-1:0] step_q;
	logic [8:0]  rem_q;
	logic [15:0] dq_q;
	logic [15:0] acc_q;
	logic [15:0] mcand_q;
	logic [8:0]  mpl_q;
	logic [16:0] idx_q;
	logic [16:0] end_q;
	logic [15:0] off_q;

	// Output register
	logic        out_valid_q;
	out_item_t   out_item_q;

	// Combinational
	logic [8:0]  c_eff;
	logic        slot_free;
	logic        in_acc;
	logic [15:0] alu_a;
	logic [15:0] alu_b;
	logic        alu_sub;
	logic [16:0] alu_sum;
	logic [9:0]  rem_sh;
	logic        div_ge;
	logic [8:0]  div_rem_nx;
	logic [15:0] div_q_nx;
	logic [16:0] div_pt;
	logic [15:0] mul_acc_nx;
	logic [WW-1:0] win;
	logic [16:0] base17;
	logic [16:0] idx_hi;
	logic [16:0] pt_m1;
	logic [16:0] hs_max;
	logic [16:0] hs_new;
	logic [16:0] burst_end;
	logic        burst_go;
	logic [16:0] aseq17;
	logic        active;
	logic        ack_ok;
	logic [3:0]  retry_inc;
	logic        give_up;
	logic [15:0] rem_bytes;
	logic        emit;
	out_item_t   out_nx;

	assign c_eff     = (chunk_size_q == 9'd0) ? 9'd1 : chunk_size_q;
	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// Shared add/sub unit: divider trial subtract or multiplier partial sum.
	assign rem_sh = {rem_q, dq_q[15]};
	always_comb begin
		if (state_q == S_DIV) begin
			alu_a   = 16'(rem_sh);
			alu_b   = 16'(c_eff);
			alu_sub = 1'b1;
		end else begin
			alu_a   = acc_q;
			alu_b   = mcand_q;
			alu_sub = 1'b0;
		end
	end
	assign alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + 17'(alu_sub);

	// Carry out of the subtract means no borrow: the quotient bit is one.
	assign div_ge     = alu_sum[16];
	assign div_rem_nx = div_ge ? alu_sum[8:0] : rem_sh[8:0];
	assign div_q_nx   = {dq_q[14:0], div_ge};
	assign div_pt     = {1'b0, div_q_nx} + 17'(div_rem_nx != 9'd0);
	assign mul_acc_nx = mpl_q[0] ? alu_sum[15:0] : acc_q;

	// Window bounds for the burst about to start.
	assign win       = (WW'(window_size_q) > WW'(MAX_WINDOW)) ? WW'(MAX_WINDOW)
	                                                         : WW'(window_size_q);
	assign base17    = {1'b0, base_q};
	assign idx_hi    = base17 + 17'(win) - 17'd1;
	assign pt_m1     = pt_q - 17'd1;
	assign hs_max    = (hs_q == SEQ_NONE || idx_hi > hs_q) ? idx_hi : hs_q;
	assign hs_new    = (hs_max > pt_m1) ? pt_m1 : hs_max;
	assign burst_end = (idx_hi > pt_m1) ? pt_m1 : idx_hi;
	assign burst_go  = (win != WW'(0)) && (base17 < pt_q);

	// Command decode
	assign aseq17    = {1'b0, in_item.ack_seq};
	assign active    = !fin_q && (pt_q != 17'd0);
	assign ack_ok    = active && (in_item.ack_type == TYPE_ACK) && (hs_q != SEQ_NONE) &&
	                   (aseq17 <= hs_q) && (ha_q == SEQ_NONE || aseq17 > ha_q);
	assign retry_inc = (retry_q == RETRY_MAX) ? RETRY_MAX : retry_q + 4'd1;
	assign give_up   = (retry_inc >= max_tries_q);

	// Bytes left from this chunk to the end; the short last chunk takes the rest.
	assign rem_bytes = data_size_q - off_q;

	always_comb begin
		emit   = 1'b0;
		out_nx = '0;
		case (state_q)
			S_BURST: begin
				emit               = slot_free;
				out_nx.kind        = KIND_DATA;
				out_nx.seq_no      = idx_q[15:0];
				out_nx.byte_offset = off_q;
				out_nx.length      = (rem_bytes >= 16'(c_eff)) ? c_eff : rem_bytes[8:0];
				out_nx.last        = (idx_q == end_q);
			end
			S_TEAR: begin
				emit        = slot_free;
				out_nx.kind = KIND_TEARDOWN;
				out_nx.last = (step_q == SW'(TEARDOWN_COUNT - 1));
			end
			S_GIVEUP: begin
				emit        = slot_free;
				out_nx.kind = KIND_GAVE_UP;
				out_nx.last = 1'b1;
			end
			default: begin
				emit   = 1'b0;
				out_nx = '0;
			end
		endcase
	end

	// Output register: load on emit, drop when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_item_q <= out_nx;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_size_q   <= DATA_SIZE_RST;
			chunk_size_q  <= CHUNK_SIZE_RST;
			window_size_q <= WINDOW_SIZE_RST;
			max_tries_q   <= MAX_TRIES_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_DATA_SIZE:   data_size_q   <= cfg_data;
				CFG_CHUNK_SIZE:  chunk_size_q  <= cfg_data[8:0];
				CFG_WINDOW_SIZE: window_size_q <= cfg_data[5:0];
				CFG_MAX_TRIES:   max_tries_q   <= cfg_data[3:0];
				default:         data_size_q   <= data_size_q;
			endcase
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			base_q  <= '0;
			hs_q    <= SEQ_NONE;
			ha_q    <= SEQ_NONE;
			retry_q <= '0;
			pt_q    <= '0;
			fin_q   <= 1'b0;
			rem_q   <= '0;
			dq_q    <= '0;
			acc_q   <= '0;
			mcand_q <= '0;
			mpl_q   <= '0;
			idx_q   <= '0;
			end_q   <= '0;
			off_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						step_q  <= '0;
						acc_q   <= '0;
						mpl_q   <= c_eff;
						case (op_t'(in_item.op))
							OP_START: begin
								// Fresh transfer: count packets first.
								base_q  <= '0;
								hs_q    <= SEQ_NONE;
								ha_q    <= SEQ_NONE;
								retry_q <= '0;
								fin_q   <= 1'b0;
								rem_q   <= '0;
								dq_q    <= data_size_q;
								state_q <= S_DIV;
							end
							OP_ACK: begin
								if (ack_ok) begin
									// Cumulative ack: slide the base past it.
									ha_q    <= aseq17;
									base_q  <= in_item.ack_seq + 16'd1;
									mcand_q <= in_item.ack_seq + 16'd1;
									retry_q <= '0;
									if (aseq17 == pt_m1) begin
										fin_q   <= 1'b1;
										state_q <= S_TEAR;
									end else if (aseq17 == hs_q) begin
										state_q <= S_MUL;
									end
								end
							end
							OP_TIMEOUT: begin
								if (active) begin
									retry_q <= retry_inc;
									mcand_q <= base_q;
									if (give_up) begin
										fin_q   <= 1'b1;
										state_q <= S_GIVEUP;
									end else begin
										state_q <= S_MUL;
									end
								end
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_DIV: begin
					rem_q  <= div_rem_nx;
					dq_q   <= div_q_nx;
					step_q <= step_q + SW'(1);
					if (step_q == SW'(DIV_STEPS - 1)) begin
						pt_q    <= div_pt;
						step_q  <= '0;
						mcand_q <= '0;
						if (div_pt == 17'd0) begin
							fin_q   <= 1'b1;
							state_q <= S_TEAR;
						end else begin
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					// Shift-add: window base times chunk size, modulo 2^16.
					acc_q   <= mul_acc_nx;
					mcand_q <= {mcand_q[14:0], 1'b0};
					mpl_q   <= {1'b0, mpl_q[8:1]};
					step_q  <= step_q + SW'(1);
					if (step_q == SW'(MUL_STEPS - 1)) begin
						step_q <= '0;
						off_q  <= mul_acc_nx;
						idx_q  <= base17;
						end_q  <= burst_end;
						if (win != WW'(0)) begin
							hs_q <= hs_new;
						end
						state_q <= burst_go ? S_BURST : S_IDLE;
					end
				end
				S_BURST: begin
					if (emit) begin
						idx_q <= idx_q + 17'd1;
						off_q <= off_q + 16'(c_eff);
						if (idx_q == end_q) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_TEAR: begin
					if (emit) begin
						step_q <= step_q + SW'(1);
						if (step_q == SW'(TEARDOWN_COUNT - 1)) begin
							step_q  <= '0;
							state_q <= S_IDLE;
						end
					end
				end
				S_GIVEUP: begin
					if (emit) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Checks
	`ASSERT_IMPLIES(a_acked_within_sent, ha_q != SEQ_NONE, (hs_q != SEQ_NONE) && (ha_q <= hs_q), "acked beyond sent")
	`ASSERT_IMPLIES(a_burst_in_range, state_q == S_BURST, idx_q <= end_q, "burst index past end")
	`ASSERT_NEXT(a_burst_ends_idle, (state_q == S_BURST) && emit && (idx_q == end_q), state_q == S_IDLE, "burst did not close")

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for go_back_n_sender_core: drives commands and register writes,
// predicts every descriptor in place and compares the output stream. Needs gbn_pkg.
module testbench;
	import gbn_pkg::*;

	localparam logic [1:0] OP_UNUSED      = 2'd3;
	localparam int         MAX_WIN        = MAX_WINDOW_DEF;
	localparam int         TEAR_N         = TEARDOWN_COUNT_DEF;
	localparam int         WATCHDOG_LIMIT = 4000;
	localparam int         HOLD_LEN       = 400;
	localparam int         DRAIN_GAP      = 80;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	in_item_t    in_item   = '0;
	logic        out_valid;
	logic        out_stall = 1'b1;
	out_item_t   out_item;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data  = '0;

	go_back_n_sender_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Shadow of the sender: register copies and transfer progress.
	logic [15:0] reg_dsize  = DATA_SIZE_RST;
	logic [8:0]  reg_chunk  = CHUNK_SIZE_RST;
	logic [5:0]  reg_win    = WINDOW_SIZE_RST;
	logic [3:0]  reg_tries  = MAX_TRIES_RST;
	logic [15:0] win_base   = '0;
	logic [16:0] top_sent   = SEQ_NONE;
	logic [16:0] top_acked  = SEQ_NONE;
	logic [3:0]  tries_used = '0;
	int          total_pkts = 0;
	bit          xfer_done  = 1'b0;

	out_item_t   want_desc[$];   // descriptors still owed by the block, oldest first
	in_item_t    cmd_pend[$];    // commands waiting for the driver
	out_item_t   head_desc;

	int cmds_queued  = 0;
	int cmds_taken   = 0;
	int regs_target  = 0;
	int regs_written = 0;
	int n_checked    = 0;
	int n_errs       = 0;
	int n_counted    = 0;
	int quiet        = 0;
	bit cmd_took     = 1'b0;

	int snd_idle   = 25;
	int rcv_idle   = 87;
	int hold_reqs  = 0;
	int hold_taken = 0;
	int hold_left  = 0;

	function automatic int seq_val(logic [16:0] v);
		return (v == SEQ_NONE) ? -1 : int'(v);
	endfunction

	task automatic report(string msg);
		n_errs++;
		$display("[tb] mismatch: %s", msg);
	endtask

	task automatic check_field(string name, int got, int exp_v);
		if (got != exp_v)
			report($sformatf("descriptor %0d %s got %0d want %0d", n_checked, name, got, exp_v));
	endtask

	task automatic add_desc(kind_t k, int seq, int off, int len);
		out_item_t d;
		d.kind        = k;
		d.seq_no      = seq[15:0];
		d.byte_offset = off[15:0];
		d.length      = len[8:0];
		d.last        = 1'b0;
		want_desc.push_back(d);
	endtask

	task automatic add_teardown();
		int k;
		for (k = 0; k < TEAR_N; k++)
			add_desc(KIND_TEARDOWN, 0, 0, 0);
		xfer_done = 1'b1;
	endtask

	// Resend the window from win_base; highest sent only grows and never passes the end.
	task automatic add_window();
		int w, c, i, idx, hs, off, len;
		w = (int'(reg_win) > MAX_WIN) ? MAX_WIN : int'(reg_win);
		c = (reg_chunk == 0) ? 1 : int'(reg_chunk);
		for (i = 0; i < w; i++) begin
			idx = int'(win_base) + i;
			hs  = seq_val(top_sent);
			if (idx > hs)
				hs = idx;
			if (hs > total_pkts - 1)
				hs = total_pkts - 1;
			top_sent = (hs < 0) ? SEQ_NONE : 17'(hs);
			if (idx < total_pkts) begin
				off = idx * c;
				len = (int'(reg_dsize) - off >= c) ? c : int'(reg_dsize) % c;
				add_desc(KIND_DATA, idx, off, len);
			end
		end
	endtask

	// Work out the descriptors one accepted command causes and append them.
	task automatic plan_descriptors(in_item_t cmd);
		int        n_before, c, aseq;
		bit        active;
		out_item_t d;
		n_before = want_desc.size();
		active   = !xfer_done && total_pkts != 0;
		aseq     = int'(cmd.ack_seq);
		case (cmd.op)
			OP_START: begin
				c          = (reg_chunk == 0) ? 1 : int'(reg_chunk);
				total_pkts = int'(reg_dsize) / c + ((int'(reg_dsize) % c != 0) ? 1 : 0);
				win_base   = '0;
				top_sent   = SEQ_NONE;
				top_acked  = SEQ_NONE;
				tries_used = '0;
				xfer_done  = 1'b0;
				if (total_pkts == 0)
					add_teardown();
				else
					add_window();
			end
			OP_ACK: begin
				if (active && cmd.ack_type == TYPE_ACK && top_sent != SEQ_NONE &&
						aseq <= int'(top_sent) && aseq > seq_val(top_acked)) begin
					top_acked  = 17'(aseq);
					win_base   = cmd.ack_seq + 16'd1;
					tries_used = '0;
					if (aseq == total_pkts - 1)
						add_teardown();
					else if (top_acked == top_sent)
						add_window();
				end
			end
			OP_TIMEOUT: begin
				if (active) begin
					if (tries_used < RETRY_MAX)
						tries_used = tries_used + 4'd1;
					if (tries_used >= reg_tries) begin
						add_desc(KIND_GAVE_UP, 0, 0, 0);
						xfer_done = 1'b1;
					end else begin
						add_window();
					end
				end
			end
			default: ;
		endcase
		if (want_desc.size() > n_before) begin
			d      = want_desc.pop_back();
			d.last = 1'b1;
			want_desc.push_back(d);
		end
	endtask

	// Sample at the rising edge: check results, then predict for the accepted command.
	always @(posedge clk) begin
		cmd_took <= in_valid && !in_stall;
		if (arst_n && out_valid && !out_stall) begin
			if (want_desc.size() == 0) begin
				report($sformatf("unexpected descriptor kind %0d seq %0d",
					out_item.kind, out_item.seq_no));
			end else begin
				head_desc = want_desc.pop_front();
				check_field("kind", int'(out_item.kind), int'(head_desc.kind));
				check_field("seq_no", int'(out_item.seq_no), int'(head_desc.seq_no));
				check_field("byte_offset", int'(out_item.byte_offset),
					int'(head_desc.byte_offset));
				check_field("length", int'(out_item.length), int'(head_desc.length));
				check_field("last", int'(out_item.last), int'(head_desc.last));
			end
			n_checked++;
		end
		if (arst_n && in_valid && !in_stall) begin
			plan_descriptors(in_item);
			cmds_taken <= cmds_taken + 1;
		end
		if (arst_n && cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_DATA_SIZE:   reg_dsize = cfg_data;
				CFG_CHUNK_SIZE:  reg_chunk = cfg_data[8:0];
				CFG_WINDOW_SIZE: reg_win   = cfg_data[5:0];
				CFG_MAX_TRIES:   reg_tries = cfg_data[3:0];
				default: ;
			endcase
			regs_written <= regs_written + 1;
		end
	end

	// Command driver: advance on acceptance, idle at random between items.
	always @(negedge clk) begin
		if (!in_valid || cmd_took) begin
			if (cmd_pend.size() != 0 && $urandom_range(99) >= snd_idle) begin
				in_item  <= cmd_pend.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Descriptor sink: random stall, plus a long hold-off whenever one is requested.
	always @(negedge clk) begin
		if (hold_taken != hold_reqs) begin
			hold_left  = HOLD_LEN;
			hold_taken = hold_reqs;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rcv_idle);
		end
	end

	// Watchdog: end the run when nothing moves for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else if (quiet >= WATCHDOG_LIMIT) begin
			$display("[go_back_n_sender_core] ERROR");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// Queue one command and hold until the block has taken it.
	task automatic issue(logic [1:0] op, logic [7:0] atype, logic [15:0] aseq);
		in_item_t it;
		it.op       = op;
		it.ack_type = atype;
		it.ack_seq  = aseq;
		cmds_queued++;
		cmd_pend.push_back(it);
		wait (cmds_taken == cmds_queued);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		regs_target++;
		wait (regs_written == regs_target);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Drain all owed descriptors; with a gap, also let a silent command finish.
	task automatic settle(bit gap);
		while (want_desc.size() != 0)
			@(posedge clk);
		if (gap)
			repeat (DRAIN_GAP) @(posedge clk);
	endtask

	task automatic program_regs(int d, int c, int w, int t);
		write_reg(CFG_DATA_SIZE, 16'(d));
		write_reg(CFG_CHUNK_SIZE, 16'(c));
		write_reg(CFG_WINDOW_SIZE, 16'(w));
		write_reg(CFG_MAX_TRIES, 16'(t));
	endtask

	// Mostly small transfers so that they finish; now and then a raw size or extreme chunk.
	task automatic pick_regs();
		int d, c, w, t, pk;
		if ($urandom_range(7) == 0) begin
			case ($urandom_range(2))
				0: c = 0;
				1: c = 1;
				default: c = 511;
			endcase
			d = $urandom_range(65535);
		end else begin
			c  = $urandom_range(511, 1);
			pk = $urandom_range(12, 1);
			d  = (pk - 1) * c + $urandom_range(c, 1);
		end
		w = ($urandom_range(4) == 0) ? $urandom_range(63) : $urandom_range(8, 1);
		t = ($urandom_range(4) == 0) ? $urandom_range(15) : $urandom_range(6, 2);
		program_regs(d, c, w, t);
	endtask

	// One transfer: start, then mostly in-window acks with timeouts, junk and restarts mixed in.
	task automatic run_transfer(bit squeeze);
		int  r, steps, lo, hi;
		logic [7:0] atype;
		if ($urandom_range(1) == 0) begin
			settle(1'b1);
			pick_regs();
		end
		issue(OP_START, 8'($urandom), 16'($urandom));
		n_counted++;
		if (squeeze)
			hold_reqs++;
		steps = 0;
		while (!xfer_done && steps < 25) begin
			steps++;
			if ($urandom_range(9) == 0)
				settle(1'b0);
			r  = $urandom_range(99);
			lo = seq_val(top_acked) + 1;
			hi = seq_val(top_sent);
			if (r < 60 && hi >= lo) begin
				issue(OP_ACK, TYPE_ACK, 16'(($urandom_range(1) == 0) ? hi : $urandom_range(hi, lo)));
				n_counted++;
			end else if (r < 75 || (r < 60 && hi < lo)) begin
				if (total_pkts != 0)
					n_counted++;
				issue(OP_TIMEOUT, 8'($urandom), 16'($urandom));
			end else if (r < 90) begin
				case ($urandom_range(3))
					0: begin
						do atype = 8'($urandom); while (atype == TYPE_ACK);
						issue(OP_ACK, atype, 16'($urandom_range(65535)));
					end
					1: issue(OP_ACK, TYPE_ACK, 16'((lo > 0) ? $urandom_range(lo - 1) : $urandom));
					2: issue(OP_ACK, TYPE_ACK, 16'($urandom_range(65535, hi + 1)));
					default: issue(OP_ACK, 8'($urandom), 16'($urandom));
				endcase
			end else if (r < 95) begin
				issue(OP_UNUSED, 8'($urandom), 16'($urandom));
			end else begin
				issue(OP_START, 8'($urandom), 16'($urandom));
				n_counted++;
			end
		end
	endtask

	initial begin : stimulus
		int ph;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: reset settings give 32 packets of 256 bytes in windows of four.
		issue(OP_START, 8'hFF, 16'hFFFF);
		issue(OP_ACK, TYPE_ACK, 16'd3);         // whole window acked, next burst
		issue(OP_ACK, 8'hFF, 16'd5);            // wrong type
		issue(OP_ACK, TYPE_ACK, 16'd2);         // stale number
		issue(OP_ACK, TYPE_ACK, 16'hFFFF);      // beyond anything sent
		issue(OP_UNUSED, 8'h00, 16'h0000);
		issue(OP_ACK, TYPE_ACK, 16'd5);         // partial ack, no burst
		issue(OP_TIMEOUT, 8'h00, 16'h0000);     // go back to the base
		issue(OP_ACK, 8'h00, 16'd9);
		issue(OP_START, 8'h00, 16'h0000);       // restart while busy
		settle(1'b1);
		write_reg(CFG_MAX_TRIES, 16'd1);
		write_reg(CFG_DATA_SIZE, 16'd0);
		issue(OP_START, 8'h00, 16'h0000);       // empty transfer tears down at once
		issue(OP_ACK, TYPE_ACK, 16'd0);         // finished: ignored
		issue(OP_TIMEOUT, 8'h00, 16'h0000);
		settle(1'b1);
		program_regs(65535, 0, 63, 1);          // chunk of one, window clamped to the max
		issue(OP_START, 8'h5A, 16'hA5A5);
		issue(OP_TIMEOUT, 8'h00, 16'h0000);     // retry limit hit: give up
		issue(OP_TIMEOUT, 8'h00, 16'h0000);
		settle(1'b1);
		program_regs(1000, 511, 0, 15);         // empty window, short last chunk
		issue(OP_START, 8'h00, 16'h0000);
		issue(OP_ACK, TYPE_ACK, 16'd0);         // nothing sent yet
		issue(OP_TIMEOUT, 8'h00, 16'h0000);
		settle(1'b1);
		write_reg(CFG_WINDOW_SIZE, 16'd2);
		issue(OP_TIMEOUT, 8'h00, 16'h0000);
		issue(OP_ACK, TYPE_ACK, 16'd1);         // final packet acked: teardown

		// Random: three idling profiles, the last with none; about 210 commands in all.
		n_counted = 0;
		for (ph = 0; ph < 3; ph++) begin
			settle(1'b1);
			snd_idle = (ph == 0) ? 25 : (ph == 1) ? 87 : 0;
			rcv_idle = (ph == 0) ? 87 : (ph == 1) ? 25 : 0;
			write_reg(CFG_WINDOW_SIZE, 16'd8);
			run_transfer(1'b1);
			while (cmds_queued < 21 + 63 * (ph + 1))
				run_transfer(1'b0);
		end

		settle(1'b1);
		$display("[tb] %0d commands sent (%0d live in the random part), %0d descriptors checked, %0d register writes",
			cmds_queued, n_counted, n_checked, regs_written);
		$display("[tb] idle profiles 25/87, 87/25 and 0/0 with a long sink hold-off in each");
		if (n_errs == 0)
			$display("[go_back_n_sender_core] OK");
		else
			$display("[go_back_n_sender_core] ERROR");
		$finish;
	end

endmodule
